### rtl/core/jadc_pkg.sv
// ----------------------------------------------------------------------------
// jadc_pkg
// shared types and constants of the joystick axis dead zone and curve unit
// ----------------------------------------------------------------------------
package jadc_pkg;

    // field and register widths
    localparam int CAL_W     = 17;
    localparam int PCT_W     = 7;
    localparam int SENS_W    = 4;
    localparam int POS_W     = 18;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DZ_PCT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS       = 3'd4;

    // register values after reset
    localparam logic [CAL_W-1:0]  RST_CAL_MIN    = 17'd0;
    localparam logic [CAL_W-1:0]  RST_CAL_CENTER = 17'd32768;
    localparam logic [CAL_W-1:0]  RST_CAL_MAX    = 17'd65536;
    localparam logic [PCT_W-1:0]  RST_DZ_PCT     = 7'd10;
    localparam logic [SENS_W-1:0] RST_SENS       = 4'd9;

    // smallest usable half span of the calibration
    localparam int MIN_HALF_SPAN = 5;

    // operand and quotient widths of the divider, q16 fraction
    localparam int OP_W      = 17;
    localparam int Q_W       = 17;
    localparam int FRAC_BITS = 16;

    // dead zone: span * percent / 100 by reciprocal multiply
    localparam int              PROD_W       = CAL_W + PCT_W;
    localparam int              DIV100_M_W   = 25;
    localparam logic [24:0]     DIV100_MUL   = 25'd21474837;
    localparam int              DIV100_SHIFT = 31;
    localparam int              DZ_W         = 18;

    // curve: four multiply-by-p steps give p^5
    localparam int              MUL_STAGES   = 4;
    localparam logic [SENS_W-1:0] SENS_MAX   = 4'd9;
    localparam int              SUM_W        = 20;
    localparam int              DIV9_M_W     = 21;
    localparam logic [20:0]     DIV9_MUL     = 21'd1864136;
    localparam int              DIV9_SHIFT   = 24;

    typedef struct packed {
        logic [CAL_W-1:0] raw_sample;
        logic             mode;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    uncalibrated;
    } t_out;

    // per-item flags that travel beside the arithmetic
    typedef struct packed {
        logic throttle;
        logic bad;
        logic zero;
        logic neg;
    } t_side;

endpackage

### rtl/core/joystick_axis_deadzone_curve_unit.sv
// ----------------------------------------------------------------------------
// joystick_axis_deadzone_curve_unit
// conditions one raw axis sample: dead zone and response curve, or throttle
// ----------------------------------------------------------------------------
// channel  handshake                 payload
// in       i_in_valid / o_in_ready   t_in  raw_sample, mode
// out      o_out_valid / i_out_ready t_out position, uncalibrated
// cfg      i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// one beat per cycle in and out unless the output beat is stalled
// the pipeline is four front stages, the 17-stage divider, four power,
// sum, divide-by-nine and output stages
// synchronous reset clears all valid bits and loads the default calibration
// a stalled output beat freezes every stage; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module joystick_axis_deadzone_curve_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  jadc_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output jadc_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [jadc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jadc_pkg::CAL_W-1:0]          i_cfg_wdata
);

    localparam int CAL_W  = jadc_pkg::CAL_W;
    localparam int PCT_W  = jadc_pkg::PCT_W;
    localparam int SENS_W = jadc_pkg::SENS_W;
    localparam int OP_W   = jadc_pkg::OP_W;
    localparam int DZ_W   = jadc_pkg::DZ_W;
    localparam int PROD_W = jadc_pkg::PROD_W;
    localparam int SUM_W  = jadc_pkg::SUM_W;
    localparam int POS_W  = jadc_pkg::POS_W;
    localparam int FRAC   = jadc_pkg::FRAC_BITS;
    localparam int NMUL   = jadc_pkg::MUL_STAGES;
    localparam int SPAN_W = CAL_W + 1;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    logic [CAL_W-1:0]  r_cal_min;
    logic [CAL_W-1:0]  r_cal_center;
    logic [CAL_W-1:0]  r_cal_max;
    logic [PCT_W-1:0]  r_dz_pct;
    logic [SENS_W-1:0] r_sens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_min    <= jadc_pkg::RST_CAL_MIN;
            r_cal_center <= jadc_pkg::RST_CAL_CENTER;
            r_cal_max    <= jadc_pkg::RST_CAL_MAX;
            r_dz_pct     <= jadc_pkg::RST_DZ_PCT;
            r_sens       <= jadc_pkg::RST_SENS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jadc_pkg::CFG_CAL_MIN:    r_cal_min    <= i_cfg_wdata;
                jadc_pkg::CFG_CAL_CENTER: r_cal_center <= i_cfg_wdata;
                jadc_pkg::CFG_CAL_MAX:    r_cal_max    <= i_cfg_wdata;
                jadc_pkg::CFG_DZ_PCT:     r_dz_pct     <= i_cfg_wdata[PCT_W-1:0];
                jadc_pkg::CFG_SENS:       r_sens       <= i_cfg_wdata[SENS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // pipeline enable: everything moves unless the output beat is held
    // ------------------------------------------------------------------------
    logic w_en;
    logic r_out_vld;

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    // ------------------------------------------------------------------------
    // stage 1: raw differences
    // ------------------------------------------------------------------------
    logic              r1_vld;
    logic              r1_mode;
    logic [SPAN_W-1:0] r1_lo_span;
    logic [SPAN_W-1:0] r1_hi_span;
    logic [SPAN_W-1:0] r1_span;
    logic [SPAN_W-1:0] r1_off;
    logic [SPAN_W-1:0] r1_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mode    <= i_in_data.mode;
            r1_lo_span <= {1'b0, r_cal_center} - {1'b0, r_cal_min};
            r1_hi_span <= {1'b0, r_cal_max} - {1'b0, r_cal_center};
            r1_span    <= {1'b0, r_cal_max} - {1'b0, r_cal_min};
            r1_off     <= {1'b0, i_in_data.raw_sample} - {1'b0, r_cal_center};
            r1_v       <= {1'b0, i_in_data.raw_sample} - {1'b0, r_cal_min};
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: calibration check, throttle clamp, span * percent
    // ------------------------------------------------------------------------
    logic              r2_vld;
    logic              r2_mode;
    logic              r2_bad;
    logic [PROD_W-1:0] r2_prod;
    logic [OP_W-1:0]   r2_lo_half;
    logic [OP_W-1:0]   r2_hi_half;
    logic [SPAN_W-1:0] r2_off;
    logic [OP_W-1:0]   r2_tnum;
    logic [OP_W-1:0]   r2_tden;
    logic              n2_bad;
    logic [OP_W-1:0]   n2_tnum;

    assign n2_bad = ($signed(r1_lo_span) < $signed(SPAN_W'(jadc_pkg::MIN_HALF_SPAN)))
                 || ($signed(r1_hi_span) < $signed(SPAN_W'(jadc_pkg::MIN_HALF_SPAN)));

    always_comb begin
        priority if (r1_v[SPAN_W-1]) begin
            n2_tnum = '0;
        end else if ($signed(r1_v) > $signed(r1_span)) begin
            n2_tnum = r1_span[OP_W-1:0];
        end else begin
            n2_tnum = r1_v[OP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mode    <= r1_mode;
            r2_bad     <= n2_bad;
            r2_prod    <= {{PCT_W{1'b0}}, r1_span[CAL_W-1:0]} * {{CAL_W{1'b0}}, r_dz_pct};
            r2_lo_half <= r1_lo_span[OP_W-1:0];
            r2_hi_half <= r1_hi_span[OP_W-1:0];
            r2_off     <= r1_off;
            r2_tnum    <= n2_tnum;
            r2_tden    <= r1_span[OP_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: dead zone = prod / 100 by reciprocal multiply
    // ------------------------------------------------------------------------
    localparam int D100_W = PROD_W + jadc_pkg::DIV100_M_W;

    logic              r3_vld;
    logic              r3_mode;
    logic              r3_bad;
    logic [DZ_W-1:0]   r3_dz;
    logic [OP_W-1:0]   r3_lo_half;
    logic [OP_W-1:0]   r3_hi_half;
    logic [SPAN_W-1:0] r3_off;
    logic [OP_W-1:0]   r3_tnum;
    logic [OP_W-1:0]   r3_tden;
    logic [D100_W-1:0] w_dz_prod;

    assign w_dz_prod = {{jadc_pkg::DIV100_M_W{1'b0}}, r2_prod}
                     * {{PROD_W{1'b0}}, jadc_pkg::DIV100_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_mode    <= r2_mode;
            r3_bad     <= r2_bad;
            r3_dz      <= w_dz_prod[jadc_pkg::DIV100_SHIFT +: DZ_W];
            r3_lo_half <= r2_lo_half;
            r3_hi_half <= r2_hi_half;
            r3_off     <= r2_off;
            r3_tnum    <= r2_tnum;
            r3_tden    <= r2_tden;
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: side of the dead zone, range and deflection
    // ------------------------------------------------------------------------
    logic signed [DZ_W:0] w_off;
    logic signed [DZ_W:0] w_dz;
    logic signed [DZ_W:0] w_lo;
    logic signed [DZ_W:0] w_hi;
    logic signed [DZ_W:0] w_rng;
    logic signed [DZ_W:0] w_d;
    logic signed [DZ_W:0] w_dcl;
    logic                 w_neg;
    logic                 w_pos;
    logic                 w_act;
    logic                 w_rng_bad;

    assign w_off     = {r3_off[SPAN_W-1], r3_off};
    assign w_dz      = {1'b0, r3_dz};
    assign w_lo      = {2'b00, r3_lo_half};
    assign w_hi      = {2'b00, r3_hi_half};
    assign w_neg     = w_off < -w_dz;
    assign w_pos     = w_off > w_dz;
    assign w_act     = w_neg || w_pos;
    assign w_rng     = w_neg ? (w_lo - w_dz) : (w_hi - w_dz);
    assign w_d       = w_neg ? (-w_off - w_dz) : (w_off - w_dz);
    assign w_rng_bad = w_rng[DZ_W] || (w_rng == '0);
    assign w_dcl     = (w_d > w_rng) ? w_rng : w_d;

    logic              r4_vld;
    logic [OP_W-1:0]   r4_num;
    logic [OP_W-1:0]   r4_den;
    jadc_pkg::t_side   r4_side;
    jadc_pkg::t_side   n4_side;

    always_comb begin
        n4_side.throttle = r3_mode;
        n4_side.bad      = r3_bad || (!r3_mode && w_act && w_rng_bad);
        n4_side.zero     = !r3_mode && !w_act;
        n4_side.neg      = w_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_num  <= r3_mode ? r3_tnum : w_dcl[OP_W-1:0];
            r4_den  <= r3_mode ? r3_tden : w_rng[OP_W-1:0];
            r4_side <= n4_side;
        end
    end

    // ------------------------------------------------------------------------
    // normalized deflection p = num * 65536 / den
    // ------------------------------------------------------------------------
    logic                    w_div_vld;
    logic [jadc_pkg::Q_W-1:0] w_div_quo;
    jadc_pkg::t_side         w_div_side;

    jadc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r4_vld),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_side),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    // ------------------------------------------------------------------------
    // power stages: pw <- floor(pw * p / 65536), four times gives p^5
    // ------------------------------------------------------------------------
    logic              r_m_vld  [NMUL];
    logic [OP_W-1:0]   r_m_p    [NMUL];
    logic [OP_W-1:0]   r_m_pw   [NMUL];
    jadc_pkg::t_side   r_m_side [NMUL];

    for (genvar j = 0; j < NMUL; j++) begin : g_pow
        logic              w_vld;
        logic [OP_W-1:0]   w_p;
        logic [OP_W-1:0]   w_pw;
        jadc_pkg::t_side   w_side;
        logic [2*OP_W-1:0] w_prod;

        if (j == 0) begin : g_head
            assign w_vld  = w_div_vld;
            assign w_p    = w_div_quo;
            assign w_pw   = w_div_quo;
            assign w_side = w_div_side;
        end else begin : g_body
            assign w_vld  = r_m_vld[j-1];
            assign w_p    = r_m_p[j-1];
            assign w_pw   = r_m_pw[j-1];
            assign w_side = r_m_side[j-1];
        end

        assign w_prod = {{OP_W{1'b0}}, w_pw} * {{OP_W{1'b0}}, w_p};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld[j] <= 1'b0;
            end else if (w_en) begin
                r_m_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_m_p[j]    <= w_p;
                r_m_pw[j]   <= w_prod[FRAC +: OP_W];
                r_m_side[j] <= w_side;
            end
        end
    end

    // ------------------------------------------------------------------------
    // blend: p * s + p^5 * (9 - s)
    // ------------------------------------------------------------------------
    localparam int BL_W = SUM_W + 1;

    logic [SENS_W-1:0] w_s;
    logic [SENS_W-1:0] w_s_inv;
    logic [BL_W-1:0]   w_lin;
    logic [BL_W-1:0]   w_crv;
    logic [BL_W-1:0]   w_sum;

    assign w_s     = (r_sens > jadc_pkg::SENS_MAX) ? jadc_pkg::SENS_MAX : r_sens;
    assign w_s_inv = jadc_pkg::SENS_MAX - w_s;
    assign w_lin   = {{(BL_W-OP_W){1'b0}}, r_m_p[NMUL-1]}
                   * {{(BL_W-SENS_W){1'b0}}, w_s};
    assign w_crv   = {{(BL_W-OP_W){1'b0}}, r_m_pw[NMUL-1]}
                   * {{(BL_W-SENS_W){1'b0}}, w_s_inv};
    assign w_sum   = w_lin + w_crv;

    logic              r_s_vld;
    logic [SUM_W-1:0]  r_s_sum;
    logic [OP_W-1:0]   r_s_p;
    jadc_pkg::t_side   r_s_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (w_en) begin
            r_s_vld <= r_m_vld[NMUL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_sum  <= w_sum[SUM_W-1:0];
            r_s_p    <= r_m_p[NMUL-1];
            r_s_side <= r_m_side[NMUL-1];
        end
    end

    // ------------------------------------------------------------------------
    // x = sum / 9 by reciprocal multiply
    // ------------------------------------------------------------------------
    localparam int D9_W = SUM_W + jadc_pkg::DIV9_M_W;

    logic [D9_W-1:0]   w_x_prod;
    logic              r_x_vld;
    logic [OP_W-1:0]   r_x;
    logic [OP_W-1:0]   r_x_p;
    jadc_pkg::t_side   r_x_side;

    assign w_x_prod = {{jadc_pkg::DIV9_M_W{1'b0}}, r_s_sum}
                    * {{SUM_W{1'b0}}, jadc_pkg::DIV9_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else if (w_en) begin
            r_x_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x      <= w_x_prod[jadc_pkg::DIV9_SHIFT +: OP_W];
            r_x_p    <= r_s_p;
            r_x_side <= r_s_side;
        end
    end

    // ------------------------------------------------------------------------
    // output register: sign, throttle select, forced zero
    // ------------------------------------------------------------------------
    jadc_pkg::t_out          r_out;
    logic signed [POS_W-1:0] n_pos;

    always_comb begin
        priority if (r_x_side.bad || r_x_side.zero) begin
            n_pos = '0;
        end else if (r_x_side.throttle) begin
            n_pos = {1'b0, r_x_p};
        end else if (r_x_side.neg) begin
            n_pos = -$signed({1'b0, r_x});
        end else begin
            n_pos = {1'b0, r_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_x_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.position     <= n_pos;
            r_out.uncalibrated <= r_x_side.bad;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_uncal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.uncalibrated) |-> (o_out_data.position == '0))
        else $error("uncalibrated beat carries a nonzero position");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.position <= 18'sd65536)
                      && (o_out_data.position >= -18'sd65536)))
        else $error("position outside full scale");

    a_div_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_vld && !r4_side.bad && !r4_side.zero)
            |-> ((r4_num <= r4_den) && (r4_den != '0)))
        else $error("divider operands out of range");

    a_div_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_vld && !w_div_side.bad && !w_div_side.zero)
            |-> (w_div_quo <= 17'd65536))
        else $error("normalized deflection above one");
`endif

endmodule

### rtl/core/jadc_div.sv
// ----------------------------------------------------------------------------
// jadc_div
// pipelined restoring divider, one quotient bit per stage: num * 2^16 / den
// ----------------------------------------------------------------------------
module jadc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [jadc_pkg::OP_W-1:0]   i_num,
    input  logic [jadc_pkg::OP_W-1:0]   i_den,
    input  jadc_pkg::t_side             i_side,
    output logic                        o_vld,
    output logic [jadc_pkg::Q_W-1:0]    o_quo,
    output jadc_pkg::t_side             o_side
);

    localparam int OP_W = jadc_pkg::OP_W;
    localparam int Q_W  = jadc_pkg::Q_W;

    logic                  r_vld  [Q_W];
    logic [Q_W-1:0]        r_quo  [Q_W];
    jadc_pkg::t_side       r_side [Q_W];
    logic [OP_W-1:0]       r_rem  [Q_W-1];
    logic [OP_W-1:0]       r_den  [Q_W-1];

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [OP_W:0]   w_trial;
        logic [OP_W:0]   w_diff;
        logic [OP_W-1:0] w_den;
        logic [Q_W-1:0]  w_quo;
        jadc_pkg::t_side w_side;
        logic            w_vld;
        logic            w_ge;

        if (k == 0) begin : g_head
            // top quotient bit: num itself against den
            assign w_trial = {1'b0, i_num};
            assign w_den   = i_den;
            assign w_quo   = '0;
            assign w_side  = i_side;
            assign w_vld   = i_vld;
        end else begin : g_body
            assign w_trial = {r_rem[k-1], 1'b0};
            assign w_den   = r_den[k-1];
            assign w_quo   = r_quo[k-1];
            assign w_side  = r_side[k-1];
            assign w_vld   = r_vld[k-1];
        end

        assign w_diff = w_trial - {1'b0, w_den};
        assign w_ge   = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k]  <= {w_quo[Q_W-2:0], w_ge};
                r_side[k] <= w_side;
            end
        end

        if (k < Q_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[OP_W-1:0] : w_trial[OP_W-1:0];
                    r_den[k] <= w_den;
                end
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_quo  = r_quo[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the joystick axis dead zone and curve unit
// ----------------------------------------------------------------------------
// samples go in over a valid/ready channel while a local predictor computes the
// conditioned position and uncalibrated flag for each one; every output beat
// is compared in order against the queue of predicted results. directed
// checks cover the dead zone edges, full deflection, throttle mapping, bad
// calibrations and a long output hold-off. random phases then reload the
// calibration and stream samples with random idling on both sides and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY   = 28;
    localparam int CAL_W     = jadc_pkg::CAL_W;
    localparam int PCT_W     = jadc_pkg::PCT_W;
    localparam int SENS_W    = jadc_pkg::SENS_W;
    localparam int POS_W     = jadc_pkg::POS_W;
    localparam int CFG_IDX_W = jadc_pkg::CFG_IDX_W;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    jadc_pkg::t_in        i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    jadc_pkg::t_out       o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = jadc_pkg::CFG_CAL_MIN;
    logic [CAL_W-1:0]     i_cfg_wdata = '0;

    // predictor copy of the calibration registers
    logic [CAL_W-1:0]  cal_min_r    = jadc_pkg::RST_CAL_MIN;
    logic [CAL_W-1:0]  cal_center_r = jadc_pkg::RST_CAL_CENTER;
    logic [CAL_W-1:0]  cal_max_r    = jadc_pkg::RST_CAL_MAX;
    logic [PCT_W-1:0]  dz_pct_r     = jadc_pkg::RST_DZ_PCT;
    logic [SENS_W-1:0] sens_r       = jadc_pkg::RST_SENS;

    jadc_pkg::t_out expected_positions[$];
    int   mismatch_count = 0;
    int   sink_hold_cycles = 0;
    bit   no_idle = 1'b0;

    joystick_axis_deadzone_curve_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic jadc_pkg::t_out predict_position(jadc_pkg::t_in s);
        longint lo, ce, hi, raw, dz, off, rng, d, p, p5, x, pos, sens;
        logic   bad;
        logic   active;
        jadc_pkg::t_out r;
        lo   = cal_min_r;
        ce   = cal_center_r;
        hi   = cal_max_r;
        raw  = s.raw_sample;
        sens = (sens_r > jadc_pkg::SENS_MAX) ? jadc_pkg::SENS_MAX : sens_r;
        pos  = 0;
        bad  = 1'b0;
        if (ce - lo < jadc_pkg::MIN_HALF_SPAN || hi - ce < jadc_pkg::MIN_HALF_SPAN) begin
            bad = 1'b1;
        end else if (s.mode) begin
            rng = hi - lo;
            d = raw - lo;
            if (d < 0) d = 0;
            if (d > rng) d = rng;
            pos = (d * 65536) / rng;
        end else begin
            dz = ((hi - lo) * longint'(dz_pct_r)) / 100;
            off = raw - ce;
            active = 1'b1;
            rng = 0;
            d = 0;
            if (off < -dz) begin
                rng = ce - lo - dz;
                d = -off - dz;
            end else if (off > dz) begin
                rng = hi - ce - dz;
                d = off - dz;
            end else begin
                active = 1'b0;
            end
            if (active) begin
                if (rng <= 0) begin
                    bad = 1'b1;
                end else begin
                    if (d > rng) d = rng;
                    p = (d * 65536) / rng;
                    p5 = p;
                    repeat (4) p5 = (p5 * p) / 65536;
                    x = (p * sens + p5 * (9 - sens)) / 9;
                    pos = (off < 0) ? -x : x;
                end
            end
        end
        r.position     = pos[POS_W-1:0];
        r.uncalibrated = bad;
        return r;
    endfunction

    // raw sample biased toward the dead zone edges and calibration limits
    function automatic logic [CAL_W-1:0] pick_raw();
        longint dz, v;
        int     sel;
        dz  = (longint'(cal_max_r) - longint'(cal_min_r)) * longint'(dz_pct_r) / 100;
        if (dz < 0) dz = 0;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            v = dz + longint'($urandom_range(0, 16)) - 8;
            v = $urandom_range(0, 1) ? longint'(cal_center_r) + v : longint'(cal_center_r) - v;
        end else if (sel < 45) begin
            v = $urandom_range(0, 1) ? longint'(cal_min_r) : longint'(cal_max_r);
            v = v + longint'($urandom_range(0, 20)) - 10;
        end else if (sel < 50) begin
            v = $urandom_range(65537, 131071);
        end else if (sel < 55) begin
            v = $urandom_range(0, 1) ? 65536 : 0;
        end else begin
            v = $urandom_range(0, 65536);
        end
        if (v < 0) v = 0;
        if (v > 131071) v = 131071;
        return v[CAL_W-1:0];
    endfunction

    // beat is left valid on return; whoever goes idle next lowers it
    task automatic send_sample(input logic [CAL_W-1:0] raw, input logic mode);
        jadc_pkg::t_in item;
        item.raw_sample = raw;
        item.mode       = mode;
        if (!no_idle && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        expected_positions.push_back(predict_position(item));
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic load_calibration(input logic [CAL_W-1:0] lo, input logic [CAL_W-1:0] ce,
                                    input logic [CAL_W-1:0] hi, input logic [CAL_W-1:0] pct_word,
                                    input logic [CAL_W-1:0] sens_word);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= jadc_pkg::CFG_CAL_MIN;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        i_cfg_index <= jadc_pkg::CFG_CAL_CENTER;
        i_cfg_wdata <= ce;
        @(posedge i_clk);
        i_cfg_index <= jadc_pkg::CFG_CAL_MAX;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        i_cfg_index <= jadc_pkg::CFG_DZ_PCT;
        i_cfg_wdata <= pct_word;
        @(posedge i_clk);
        i_cfg_index <= jadc_pkg::CFG_SENS;
        i_cfg_wdata <= sens_word;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cal_min_r    = lo;
        cal_center_r = ce;
        cal_max_r    = hi;
        dz_pct_r     = pct_word[PCT_W-1:0];
        sens_r       = sens_word[SENS_W-1:0];
    endtask

    // reset calibration: dead zone is 6553 counts either side of 32768
    task automatic test_reset_defaults();
        send_sample(17'd0, 1'b0);
        send_sample(17'd65536, 1'b0);
        send_sample(17'd32768, 1'b0);
        send_sample(17'd39321, 1'b0);
        send_sample(17'd39322, 1'b0);
        send_sample(17'd26215, 1'b0);
        send_sample(17'd26214, 1'b0);
        send_sample(17'd131071, 1'b0);
        send_sample(17'd0, 1'b1);
        send_sample(17'd65536, 1'b1);
        send_sample(17'd32768, 1'b1);
    endtask

    task automatic test_calibration_extremes();
        // lower half span one short
        load_calibration(17'd0, 17'd4, 17'd65536, 17'd10, 17'd9);
        send_sample(17'd100, 1'b0);
        send_sample(17'd100, 1'b1);
        // upper half span one short
        load_calibration(17'd0, 17'd65532, 17'd65536, 17'd10, 17'd9);
        send_sample(17'd65536, 1'b1);
        // narrowest usable spans, pure fifth power curve
        load_calibration(17'd0, 17'd5, 17'd10, 17'd0, 17'd0);
        send_sample(17'd0, 1'b0);
        send_sample(17'd10, 1'b0);
        send_sample(17'd7, 1'b0);
        send_sample(17'd3, 1'b1);
        // minimum above center
        load_calibration(17'd40000, 17'd30000, 17'd65536, 17'd10, 17'd9);
        send_sample(17'd50000, 1'b0);
        // dead zone eats the lower half, sensitivity past nine
        load_calibration(17'd0, 17'd10000, 17'd65536, 17'd60, 17'd15);
        send_sample(17'd0, 1'b0);
        send_sample(17'd65536, 1'b0);
        send_sample(17'd10000, 1'b0);
        // widest dead zone setting
        load_calibration(17'd0, 17'd32768, 17'd65536, 17'd127, 17'd5);
        send_sample(17'd0, 1'b0);
        send_sample(17'd131071, 1'b0);
    endtask

    // output held off while input keeps coming, so the pipe fills and stalls
    task automatic test_backpressure();
        load_calibration(17'd1000, 17'd33000, 17'd64000, 17'd5, 17'd4);
        no_idle = 1'b1;
        sink_hold_cycles = 200;
        repeat (80) send_sample(pick_raw(), 1'($urandom_range(0, 1)));
        no_idle = 1'b0;
        drain_results();
    endtask

    task automatic test_random_samples();
        int               kind;
        int               pct;
        logic [CAL_W-1:0] lo, ce, hi, pct_word;
        for (int phase = 0; phase < 10; phase++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                lo = CAL_W'($urandom_range(0, 60000));
                ce = CAL_W'(lo + $urandom_range(0, 6));
                hi = CAL_W'(ce + $urandom_range(0, 6));
            end else if (kind == 1) begin
                lo = 17'd0;
                hi = 17'd65536;
                ce = CAL_W'($urandom_range(5, 65531));
            end else begin
                lo = CAL_W'($urandom_range(0, 30000));
                hi = CAL_W'($urandom_range(35000, 65536));
                ce = CAL_W'($urandom_range(lo + 5, hi - 5));
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) pct = $urandom_range(0, 30);
            else if (kind < 9) pct = $urandom_range(31, 100);
            else pct = $urandom_range(101, 127);
            pct_word = CAL_W'(pct);
            // junk above the register width must be dropped
            if ($urandom_range(0, 3) == 0) pct_word[CAL_W-1:PCT_W] = (CAL_W-PCT_W)'($urandom);
            load_calibration(lo, ce, hi, pct_word, 17'($urandom_range(0, 15)));
            no_idle = (phase == 3);
            repeat (100) send_sample(pick_raw(), 1'($urandom_range(0, 1)));
            no_idle = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            sink_hold_cycles = sink_hold_cycles - 1;
        end else if (!no_idle) begin
            i_out_ready <= ($urandom_range(0, 99) >= 11);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        jadc_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_positions.size() == 0) begin
                $display("%0t: unexpected beat, position %0d uncalibrated %0b", $time,
                         o_out_data.position, o_out_data.uncalibrated);
                mismatch_count++;
            end else begin
                want = expected_positions.pop_front();
                if (o_out_data.position !== want.position) begin
                    $display("%0t: position expected %0d actual %0d", $time,
                             want.position, o_out_data.position);
                    mismatch_count++;
                end
                if (o_out_data.uncalibrated !== want.uncalibrated) begin
                    $display("%0t: uncalibrated expected %0b actual %0b", $time,
                             want.uncalibrated, o_out_data.uncalibrated);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_calibration_extremes();
        test_backpressure();
        test_random_samples();
        drain_results();
        if (mismatch_count == 0 && expected_positions.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
